/* hdl/slcd_pkg.sv */
// Shared constants and types for the SPI LCD command decoder and pixel writer.
`default_nettype none

package slcd_pkg;

    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 320;

    localparam int ADDR_W  = 17;
    localparam int COLOR_W = 16;
    localparam int CUR_W   = 17;
    localparam int WIN_W   = 16;
    localparam int X_W     = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int Y_W     = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    localparam logic [7:0] CMD_CASET  = 8'h2A;
    localparam logic [7:0] CMD_RASET  = 8'h2B;
    localparam logic [7:0] CMD_MADCTL = 8'h36;
    localparam logic [7:0] CMD_RAMWR  = 8'h2C;
    localparam logic [7:0] CMD_COLMOD = 8'h3A;
    localparam logic [7:0] CMD_INVOFF = 8'h20;
    localparam logic [7:0] CMD_INVON  = 8'h21;
    localparam logic [7:0] CMD_DISPON = 8'h29;

    // orientation bits as kept from MADCTL bits 7:5
    localparam int ORIENT_SWAP = 0;
    localparam int ORIENT_MX   = 1;
    localparam int ORIENT_MY   = 2;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'b001,
        MODE_PARAM = 3'b010,
        MODE_PIXEL = 3'b100
    } mode_t;

    // one pixel ready to be placed, from the decoder to the mapper
    typedef struct packed {
        logic               valid;
        logic [CUR_W-1:0]   col;
        logic [CUR_W-1:0]   row;
        logic [COLOR_W-1:0] color;
        logic [2:0]         orient;
    } pix_t;

endpackage

`default_nettype wire

/* hdl/slcd_ctrl.sv */
// Command decoder: parameter capture, window and orientation registers, pixel cursor.
`default_nettype none

module slcd_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic        operation,
    input  wire logic [7:0]  byte_value,
    input  wire logic        dc_pin,
    input  wire logic        cs_level,
    output slcd_pkg::pix_t   pix
);

    logic                            sel_reg, sel_next;
    logic [7:0]                      cmd_reg, cmd_next;
    logic [7:0]                      pb_reg [0:2];
    logic [2:0]                      cnt_reg, cnt_next;
    slcd_pkg::mode_t                 mode_reg, mode_next;
    logic [slcd_pkg::WIN_W-1:0]      col_first_reg, col_first_next;
    logic [slcd_pkg::WIN_W-1:0]      col_last_reg, col_last_next;
    logic [slcd_pkg::WIN_W-1:0]      row_first_reg, row_first_next;
    logic [slcd_pkg::WIN_W-1:0]      row_last_reg, row_last_next;
    logic [2:0]                      orient_reg, orient_next;
    logic [slcd_pkg::CUR_W-1:0]      cur_col_reg, cur_col_next;
    logic [slcd_pkg::CUR_W-1:0]      cur_row_reg, cur_row_next;

    logic                            pb_we;
    logic [1:0]                      pb_idx;
    logic [2:0]                      cnt_inc;
    logic                            need4;
    logic                            done;
    logic [slcd_pkg::CUR_W-1:0]      col_inc;
    logic [slcd_pkg::CUR_W-1:0]      row_inc;

    always_comb begin
        sel_next       = sel_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        row_first_next = row_first_reg;
        row_last_next  = row_last_reg;
        orient_next    = orient_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        pb_we          = 1'b0;
        pb_idx         = cnt_reg[1:0];
        cnt_inc        = cnt_reg + 3'd1;
        need4          = (cmd_reg == slcd_pkg::CMD_CASET) || (cmd_reg == slcd_pkg::CMD_RASET);
        done           = cnt_inc >= (need4 ? 3'd4 : 3'd1);
        col_inc        = cur_col_reg + 1'b1;
        row_inc        = cur_row_reg + 1'b1;

        pix.valid  = 1'b0;
        pix.col    = cur_col_reg;
        pix.row    = cur_row_reg;
        pix.color  = {pb_reg[0], byte_value};
        pix.orient = orient_reg;

        if (step) begin
            priority if (operation) begin
                sel_next     = cs_level;
                cur_col_next = '0;
                cur_row_next = '0;
            end else if (!sel_reg) begin
                // deselected: byte dropped
            end else if (!dc_pin) begin
                cmd_next = byte_value;
                cnt_next = '0;
                unique case (byte_value)
                    slcd_pkg::CMD_CASET, slcd_pkg::CMD_RASET, slcd_pkg::CMD_MADCTL,
                    slcd_pkg::CMD_COLMOD, slcd_pkg::CMD_INVOFF, slcd_pkg::CMD_INVON,
                    slcd_pkg::CMD_DISPON: begin
                        mode_next = slcd_pkg::MODE_PARAM;
                    end
                    slcd_pkg::CMD_RAMWR: begin
                        mode_next    = slcd_pkg::MODE_PIXEL;
                        cur_col_next = {1'b0, col_first_reg};
                        cur_row_next = {1'b0, row_first_reg};
                    end
                    default: begin
                        mode_next = slcd_pkg::MODE_NONE;
                    end
                endcase
            end else begin
                unique case (mode_reg)
                    slcd_pkg::MODE_PARAM: begin
                        pb_we    = 1'b1;
                        cnt_next = done ? 3'd0 : cnt_inc;
                        if (done) begin
                            mode_next = slcd_pkg::MODE_NONE;
                            // last window byte is the current beat
                            if (cmd_reg == slcd_pkg::CMD_CASET) begin
                                col_first_next = {pb_reg[0], pb_reg[1]};
                                col_last_next  = {pb_reg[2], byte_value};
                            end else if (cmd_reg == slcd_pkg::CMD_RASET) begin
                                row_first_next = {pb_reg[0], pb_reg[1]};
                                row_last_next  = {pb_reg[2], byte_value};
                            end else if (cmd_reg == slcd_pkg::CMD_MADCTL) begin
                                orient_next = byte_value[7:5];
                            end
                        end
                    end
                    slcd_pkg::MODE_PIXEL: begin
                        pb_we  = 1'b1;
                        pb_idx = {1'b0, cnt_reg[0]};
                        if (cnt_reg != 3'd0) begin
                            pix.valid = 1'b1;
                            cnt_next  = '0;
                            cur_col_next = col_inc;
                            if (col_inc > {1'b0, col_last_reg}) begin
                                cur_col_next = {1'b0, col_first_reg};
                                cur_row_next = row_inc;
                                if (row_inc > {1'b0, row_last_reg}) begin
                                    cur_row_next = {1'b0, row_first_reg};
                                end
                            end
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    default: begin
                        // no parameters expected: data dropped
                    end
                endcase
            end
        end
    end

    // fourth window byte is never stored, it is used as it arrives
    always_ff @(posedge aclk) begin
        if (pb_we && pb_idx != 2'd3) begin
            pb_reg[pb_idx] <= byte_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg       <= 1'b0;
            cmd_reg       <= '0;
            cnt_reg       <= '0;
            mode_reg      <= slcd_pkg::MODE_NONE;
            col_first_reg <= '0;
            col_last_reg  <= '0;
            row_first_reg <= '0;
            row_last_reg  <= '0;
            orient_reg    <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
        end else begin
            sel_reg       <= sel_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            col_first_reg <= col_first_next;
            col_last_reg  <= col_last_next;
            row_first_reg <= row_first_next;
            row_last_reg  <= row_last_next;
            orient_reg    <= orient_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/slcd_map.sv */
// Pixel mapper: swap and mirror, panel bounds check, frame-buffer address.
`default_nettype none

module slcd_map (
    input  wire slcd_pkg::pix_t           pix,
    output logic                          hit,
    output logic [slcd_pkg::ADDR_W-1:0]   address
);

    logic [slcd_pkg::CUR_W-1:0]  x;
    logic [slcd_pkg::CUR_W-1:0]  y;
    logic [slcd_pkg::X_W-1:0]    xm;
    logic [slcd_pkg::Y_W-1:0]    ym;

    // a mirrored coordinate lands on the panel exactly when the unmirrored one does
    always_comb begin
        x = pix.orient[slcd_pkg::ORIENT_SWAP] ? pix.row : pix.col;
        y = pix.orient[slcd_pkg::ORIENT_SWAP] ? pix.col : pix.row;
        hit = pix.valid
            && (x < slcd_pkg::CUR_W'(slcd_pkg::PANEL_WIDTH))
            && (y < slcd_pkg::CUR_W'(slcd_pkg::PANEL_HEIGHT));
        xm = pix.orient[slcd_pkg::ORIENT_MX]
            ? slcd_pkg::X_W'(slcd_pkg::PANEL_WIDTH - 1) - x[slcd_pkg::X_W-1:0]
            : x[slcd_pkg::X_W-1:0];
        ym = pix.orient[slcd_pkg::ORIENT_MY]
            ? slcd_pkg::Y_W'(slcd_pkg::PANEL_HEIGHT - 1) - y[slcd_pkg::Y_W-1:0]
            : y[slcd_pkg::Y_W-1:0];
        address = slcd_pkg::ADDR_W'(ym) * slcd_pkg::ADDR_W'(slcd_pkg::PANEL_WIDTH)
                + slcd_pkg::ADDR_W'(xm);
    end

endmodule

`default_nettype wire

/* hdl/spi_lcd_command_pixel_writer_top.sv */
// SPI LCD command decoder and pixel writer, top level with input and result registers.
//
// Input channel (s_*): one beat per SPI event. s_operation 0 carries one SPI
// byte (s_byte_value) with its data/command level (s_dc_pin); s_operation 1
// is a chip-select change to s_cs_level, which also zeroes the pixel cursor.
// Bytes arriving while deselected are dropped.
// Result channel (m_*): one frame-buffer write (m_pixel_address,
// m_pixel_color) for each second RAMWR data byte whose pixel lies on the
// panel; all other beats produce nothing.
// A beat passes through the input register, then the result register, which
// drives m_valid. Throughput: one beat per cycle while the receiver does not
// stall, set by the single decode/address pass between the two registers.
// Reset (aresetn low, synchronous) empties both registers, deselects the
// panel and clears command, window, orientation and cursor.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_ready then drops until m_ready.
`default_nettype none

module spi_lcd_command_pixel_writer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_operation,
    input  wire logic [7:0]                      s_byte_value,
    input  wire logic                            s_dc_pin,
    input  wire logic                            s_cs_level,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [slcd_pkg::ADDR_W-1:0]          m_pixel_address,
    output logic [slcd_pkg::COLOR_W-1:0]         m_pixel_color
);

    logic                            in_valid_reg, in_valid_next;
    logic                            in_op_reg;
    logic [7:0]                      in_byte_reg;
    logic                            in_dc_reg;
    logic                            in_cs_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [slcd_pkg::ADDR_W-1:0]     out_addr_reg;
    logic [slcd_pkg::COLOR_W-1:0]    out_color_reg;

    logic                            adv;
    logic                            step;
    slcd_pkg::pix_t                  pix;
    logic                            hit;
    logic [slcd_pkg::ADDR_W-1:0]     address;

    assign adv     = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;

    assign m_valid         = out_valid_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_pixel_color   = out_color_reg;

    slcd_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .operation  (in_op_reg),
        .byte_value (in_byte_reg),
        .dc_pin     (in_dc_reg),
        .cs_level   (in_cs_reg),
        .pix        (pix)
    );

    slcd_map u_map (
        .pix     (pix),
        .hit     (hit),
        .address (address)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        if (adv) begin
            out_valid_next = step && hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_byte_reg <= s_byte_value;
            in_dc_reg   <= s_dc_pin;
            in_cs_reg   <= s_cs_level;
        end
        if (step) begin
            out_addr_reg  <= address;
            out_color_reg <= pix.color;
        end
    end

    // a held input beat is not lost while the result side is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> in_valid_reg)
        else $error("input beat dropped while stalled");

    // a chip-select beat never produces a pixel write
    a_cs_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_op_reg) |=> !out_valid_reg)
        else $error("pixel write from chip-select beat");

    // written addresses stay inside the frame buffer
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((slcd_pkg::PANEL_WIDTH * slcd_pkg::PANEL_HEIGHT >= (1 << slcd_pkg::ADDR_W))
                           || (32'(out_addr_reg) < 32'(slcd_pkg::PANEL_WIDTH * slcd_pkg::PANEL_HEIGHT))))
        else $error("pixel address beyond panel");

    // reset empties both registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("registers not empty after reset");

endmodule

`default_nettype wire

/* tb/spi_lcd_fb_write_checker.sv */
// Checker for the SPI LCD pixel writer: tracks panel state and compares frame-buffer writes.
`timescale 1ns / 100ps

module spi_lcd_fb_write_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic                         s_operation,
    input  wire logic [7:0]                   s_byte_value,
    input  wire logic                         s_dc_pin,
    input  wire logic                         s_cs_level,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic [slcd_pkg::ADDR_W-1:0]  m_pixel_address,
    input  wire logic [slcd_pkg::COLOR_W-1:0] m_pixel_color,
    output int                                mismatch_count,
    output int                                expected_left,
    output int                                writes_checked
);

    typedef struct {
        logic [slcd_pkg::ADDR_W-1:0]  addr;
        logic [slcd_pkg::COLOR_W-1:0] color;
    } fb_write_t;

    fb_write_t write_queue[$];

    logic                       sel;
    logic [7:0]                 cmd;
    logic [7:0]                 pbytes[4];
    logic [2:0]                 pcount;
    slcd_pkg::mode_t            mode;
    logic [slcd_pkg::WIN_W-1:0] col_lo, col_hi, row_lo, row_hi;
    logic [2:0]                 orient;
    logic [slcd_pkg::CUR_W-1:0] cur_col, cur_row;

    task automatic reset_panel_state();
        sel = 1'b0;
        cmd = '0;
        pbytes = '{default: '0};
        pcount = '0;
        mode = slcd_pkg::MODE_NONE;
        col_lo = '0;
        col_hi = '0;
        row_lo = '0;
        row_hi = '0;
        orient = '0;
        cur_col = '0;
        cur_row = '0;
    endtask

    task automatic take_command(input logic [7:0] b);
        cmd = b;
        pcount = '0;
        case (b)
            slcd_pkg::CMD_CASET, slcd_pkg::CMD_RASET, slcd_pkg::CMD_MADCTL,
            slcd_pkg::CMD_COLMOD, slcd_pkg::CMD_INVOFF, slcd_pkg::CMD_INVON,
            slcd_pkg::CMD_DISPON: begin
                mode = slcd_pkg::MODE_PARAM;
            end
            slcd_pkg::CMD_RAMWR: begin
                mode = slcd_pkg::MODE_PIXEL;
                cur_col = {1'b0, col_lo};
                cur_row = {1'b0, row_lo};
            end
            default: begin
                mode = slcd_pkg::MODE_NONE;
            end
        endcase
    endtask

    task automatic take_param(input logic [7:0] b);
        int need;
        need = (cmd == slcd_pkg::CMD_CASET || cmd == slcd_pkg::CMD_RASET) ? 4 : 1;
        pbytes[pcount[1:0]] = b;
        pcount = pcount + 3'd1;
        if (pcount >= need) begin
            if (cmd == slcd_pkg::CMD_CASET) begin
                col_lo = {pbytes[0], pbytes[1]};
                col_hi = {pbytes[2], pbytes[3]};
            end else if (cmd == slcd_pkg::CMD_RASET) begin
                row_lo = {pbytes[0], pbytes[1]};
                row_hi = {pbytes[2], pbytes[3]};
            end else if (cmd == slcd_pkg::CMD_MADCTL) begin
                orient = pbytes[0][7:5];
            end
            mode = slcd_pkg::MODE_NONE;
            pcount = '0;
        end
    endtask

    task automatic take_pixel_byte(input logic [7:0] b);
        int x, y, t, a;
        fb_write_t w;
        pbytes[{1'b0, pcount[0]}] = b;
        pcount = pcount + 3'd1;
        if (pcount >= 2) begin
            pcount = '0;
            x = int'(cur_col);
            y = int'(cur_row);
            if (orient[slcd_pkg::ORIENT_SWAP]) begin
                t = x;
                x = y;
                y = t;
            end
            if (orient[slcd_pkg::ORIENT_MX]) x = slcd_pkg::PANEL_WIDTH - 1 - x;
            if (orient[slcd_pkg::ORIENT_MY]) y = slcd_pkg::PANEL_HEIGHT - 1 - y;
            // off-panel pixels are dropped but still move the cursor
            if (x >= 0 && x < slcd_pkg::PANEL_WIDTH
                && y >= 0 && y < slcd_pkg::PANEL_HEIGHT) begin
                a = y * slcd_pkg::PANEL_WIDTH + x;
                w.addr = a[slcd_pkg::ADDR_W-1:0];
                w.color = {pbytes[0], pbytes[1]};
                write_queue.push_back(w);
            end
            cur_col = cur_col + 1'b1;
            if (cur_col > {1'b0, col_hi}) begin
                cur_col = {1'b0, col_lo};
                cur_row = cur_row + 1'b1;
                if (cur_row > {1'b0, row_hi}) cur_row = {1'b0, row_lo};
            end
        end
    endtask

    task automatic apply_spi_event(input logic op, input logic [7:0] b,
                                   input logic dc, input logic cs);
        if (op) begin
            sel = cs;
            cur_col = '0;
            cur_row = '0;
        end else if (sel) begin
            if (!dc) take_command(b);
            else if (mode == slcd_pkg::MODE_PARAM) take_param(b);
            else if (mode == slcd_pkg::MODE_PIXEL) take_pixel_byte(b);
        end
    endtask

    always @(posedge aclk) begin
        fb_write_t exp_w;
        if (!aresetn) begin
            reset_panel_state();
            write_queue.delete();
            mismatch_count = 0;
            writes_checked = 0;
        end else begin
            // result side first: a beat accepted now never answers this edge's input
            if (m_valid && m_ready) begin
                writes_checked++;
                if (write_queue.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected write addr %0d color %h", $time,
                                 m_pixel_address, m_pixel_color);
                    mismatch_count++;
                end else begin
                    exp_w = write_queue.pop_front();
                    if (m_pixel_address !== exp_w.addr || m_pixel_color !== exp_w.color) begin
                        if (mismatch_count < 10)
                            $display("%0t: expected addr %0d color %h, got addr %0d color %h",
                                     $time, exp_w.addr, exp_w.color,
                                     m_pixel_address, m_pixel_color);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                apply_spi_event(s_operation, s_byte_value, s_dc_pin, s_cs_level);
        end
        expected_left = write_queue.size();
    end

endmodule

/* tb/spi_lcd_command_pixel_writer_top_test.sv */
// Testbench top for the SPI LCD pixel writer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module spi_lcd_command_pixel_writer_top_test;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 340;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_operation;
    logic [7:0]                    s_byte_value;
    logic                          s_dc_pin;
    logic                          s_cs_level;
    logic                          m_valid;
    logic                          m_ready;
    logic [slcd_pkg::ADDR_W-1:0]   m_pixel_address;
    logic [slcd_pkg::COLOR_W-1:0]  m_pixel_color;

    int mismatches;
    int writes_pending;
    int writes_seen;

    int  idle_pct;
    int  stall_pct;
    logic hold_req;
    logic hold_done;
    logic sel_level;
    int  beats_sent;
    int  counted;
    int  stuck_cycles;

    logic [7:0] discard_cmds[4] = '{slcd_pkg::CMD_COLMOD, slcd_pkg::CMD_INVOFF,
                                    slcd_pkg::CMD_INVON, slcd_pkg::CMD_DISPON};

    spi_lcd_command_pixel_writer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_byte_value    (s_byte_value),
        .s_dc_pin        (s_dc_pin),
        .s_cs_level      (s_cs_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color)
    );

    spi_lcd_fb_write_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_byte_value    (s_byte_value),
        .s_dc_pin        (s_dc_pin),
        .s_cs_level      (s_cs_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .mismatch_count  (mismatches),
        .expected_left   (writes_pending),
        .writes_checked  (writes_seen)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (!hold_req) hold_done = 1'b0;
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input logic op, input logic [7:0] b,
                             input logic dc, input logic cs);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_byte_value = b;
        s_dc_pin = dc;
        s_cs_level = cs;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
        if (op || sel_level) counted++;
        if (op) sel_level = cs;
    endtask

    task automatic send_cmd(input logic [7:0] c);
        send_beat(1'b0, c, 1'b0, 1'($urandom));
    endtask

    task automatic send_data(input logic [7:0] b);
        send_beat(1'b0, b, 1'b1, 1'($urandom));
    endtask

    task automatic set_select(input logic lvl);
        send_beat(1'b1, 8'($urandom), 1'($urandom), lvl);
    endtask

    task automatic send_window(input logic [7:0] c, input logic [15:0] lo,
                               input logic [15:0] hi);
        send_cmd(c);
        send_data(lo[15:8]);
        send_data(lo[7:0]);
        send_data(hi[15:8]);
        send_data(hi[7:0]);
    endtask

    task automatic send_pixel(input logic [15:0] color);
        send_data(color[15:8]);
        send_data(color[7:0]);
    endtask

    task automatic pick_span(input int extent, output logic [15:0] lo, output logic [15:0] hi);
        int r;
        r = $urandom_range(9);
        case (r)
            0: begin
                lo = 16'($urandom);
                hi = 16'($urandom);
            end
            1: begin
                // straddles the panel edge
                lo = 16'(extent - $urandom_range(1, 4));
                hi = 16'(extent + $urandom_range(0, 3));
            end
            2: begin
                // inverted: cursor sticks at the start
                hi = 16'($urandom_range(0, extent - 1));
                lo = hi + 16'($urandom_range(1, 4));
            end
            default: begin
                lo = 16'($urandom_range(0, extent - 1));
                hi = lo + 16'($urandom_range(0, 7));
            end
        endcase
    endtask

    task automatic send_frame();
        logic [15:0] lo, hi;
        int npix;
        if (!sel_level || $urandom_range(7) == 0) set_select(1'b1);
        if ($urandom_range(2) != 0) begin
            pick_span(slcd_pkg::PANEL_WIDTH, lo, hi);
            send_window(slcd_pkg::CMD_CASET, lo, hi);
        end
        if ($urandom_range(2) != 0) begin
            pick_span(slcd_pkg::PANEL_HEIGHT, lo, hi);
            send_window(slcd_pkg::CMD_RASET, lo, hi);
        end
        if ($urandom_range(2) == 0) begin
            send_cmd(slcd_pkg::CMD_MADCTL);
            send_data(8'($urandom));
        end
        if ($urandom_range(5) == 0) begin
            send_cmd(discard_cmds[$urandom_range(3)]);
            send_data(8'($urandom));
        end
        send_cmd(slcd_pkg::CMD_RAMWR);
        npix = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
        repeat (npix) begin
            // select pulses mid-stream: cursor to zero, half pixel kept
            if ($urandom_range(39) == 0) set_select(1'b1);
            send_data(8'($urandom));
            if ($urandom_range(39) == 0) set_select(1'b1);
            send_data(8'($urandom));
        end
        if ($urandom_range(3) == 0) send_data(8'($urandom));
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(9);
        case (r)
            0, 1, 2, 3: send_beat(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            4, 5: send_data(8'($urandom));
            6, 7: send_cmd(8'($urandom));
            8: begin
                set_select(1'b0);
                repeat ($urandom_range(1, 4)) send_beat(1'b0, 8'($urandom), 1'($urandom),
                                                        1'($urandom));
                set_select(1'b1);
            end
            default: begin
                send_cmd(discard_cmds[$urandom_range(3)]);
                send_data(8'($urandom));
                if ($urandom_range(1) == 0) send_data(8'($urandom));
            end
        endcase
    endtask

    task automatic drain_writes();
        s_valid = 1'b0;
        while (writes_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int target;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = 1'b0;
        s_byte_value = '0;
        s_dc_pin = 1'b0;
        s_cs_level = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        sel_level = 1'b0;
        beats_sent = 0;
        counted = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: deselected byte, bottom-right corner, full orientation, discarded param
        set_select(1'b0);
        send_data(8'hFF);
        set_select(1'b1);
        send_window(slcd_pkg::CMD_CASET, 16'd238, 16'd239);
        send_window(slcd_pkg::CMD_RASET, 16'd319, 16'd319);
        send_cmd(slcd_pkg::CMD_RAMWR);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_cmd(slcd_pkg::CMD_MADCTL);
        send_data(8'hE0);
        send_cmd(slcd_pkg::CMD_RAMWR);
        send_pixel(16'hA55A);
        send_cmd(slcd_pkg::CMD_COLMOD);
        send_data(8'h55);
        send_data(8'h00);
        set_select(1'b1);
        drain_writes();

        // back-pressure: receiver holds off while pixels keep coming
        hold_req = 1'b1;
        send_window(slcd_pkg::CMD_CASET, 16'd0, 16'd15);
        send_window(slcd_pkg::CMD_RASET, 16'd0, 16'd15);
        send_cmd(slcd_pkg::CMD_MADCTL);
        send_data(8'h00);
        send_cmd(slcd_pkg::CMD_RAMWR);
        repeat (40) send_pixel(16'($urandom));
        s_valid = 1'b0;
        wait (hold_done);
        hold_req = 1'b0;
        drain_writes();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            target = counted + PHASE_BEATS;
            while (counted < target) begin
                if ($urandom_range(4) == 0) send_noise();
                else send_frame();
            end
            drain_writes();
        end

        $display("Covered %0d input beats over four idle/stall mixes and a %0d-cycle hold-off.",
                 beats_sent, HOLD_CYCLES);
        $display("Compared %0d frame-buffer writes, %0d mismatched.", writes_seen, mismatches);
        if (mismatches == 0 && writes_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
